// File: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// Holds the register index codes, the configuration bundle and the fixed
// field widths used by the scheduler modules.
// ----------------------------------------------------------------------------
package ptts_pkg;

   // Fixed field widths.
   localparam int SLOT_BYTE_BITS  = 8;
   localparam int TASK_ID_BITS    = 4;
   localparam int TASK_COUNT_BITS = 4;
   localparam int PACKED_BITS     = 64;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int REQ_DATA_BITS   = 8;
   localparam int RSP_DATA_BITS   = 8;

   // Register reset values.
   localparam logic [TASK_COUNT_BITS-1:0] TASK_COUNT_RESET = 4'd1;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TASK_COUNT  = 2'd0,
      CSR_POLICY_MODE = 2'd1,
      CSR_EXEC_TIMES  = 2'd2,
      CSR_PERIODS     = 2'd3
   } csr_index_type;

   // Scheduling policies.
   localparam logic POLICY_RATE_MONOTONIC = 1'b0;
   localparam logic POLICY_EARLIEST_DL    = 1'b1;

   // Current configuration as seen by the scheduling logic.
   typedef struct packed {
      logic [TASK_COUNT_BITS-1:0] task_count;
      logic                       policy_mode;
      logic [PACKED_BITS-1:0]     exec_times;
      logic [PACKED_BITS-1:0]     periods;
   } cfg_type;

endpackage

// File: rtl/ptts_csr.sv
// ----------------------------------------------------------------------------
// ptts_csr: configuration registers
// Write-only register file for slot count, policy, execution times and
// periods. Unknown indexes cannot occur at this index width.
// ----------------------------------------------------------------------------
module ptts_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [ptts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ptts_pkg::PACKED_BITS-1:0]     csr_wdata,
   output ptts_pkg::cfg_type                    cfg
);

   ptts_pkg::cfg_type cfg_ff;
   ptts_pkg::cfg_type cfg_in;

   // Decode a write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (ptts_pkg::csr_index_type'(csr_index))
            ptts_pkg::CSR_TASK_COUNT: begin
               cfg_in.task_count = csr_wdata[ptts_pkg::TASK_COUNT_BITS-1:0];
            end
            ptts_pkg::CSR_POLICY_MODE: begin
               cfg_in.policy_mode = csr_wdata[0];
            end
            ptts_pkg::CSR_EXEC_TIMES: begin
               cfg_in.exec_times = csr_wdata;
            end
            ptts_pkg::CSR_PERIODS: begin
               cfg_in.periods = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.task_count  <= ptts_pkg::TASK_COUNT_RESET;
         cfg_ff.policy_mode <= ptts_pkg::POLICY_RATE_MONOTONIC;
         cfg_ff.exec_times  <= '0;
         cfg_ff.periods     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ptts_select.sv
// ----------------------------------------------------------------------------
// ptts_select: priority pick among pending tasks
// Finds the candidate slot with the smallest key; equal keys go to the
// lowest slot. The result is a one-hot grant, all zero when idle.
// ----------------------------------------------------------------------------
module ptts_select #(
   parameter int TASK_SLOTS = 8
) (
   input  logic [TASK_SLOTS-1:0]                              cand,
   input  logic [TASK_SLOTS-1:0][ptts_pkg::SLOT_BYTE_BITS-1:0] key,
   output logic [TASK_SLOTS-1:0]                              grant
);

   // Linear scan: a later slot wins only with a strictly smaller key.
   always_comb begin
      logic                                have;
      logic [ptts_pkg::SLOT_BYTE_BITS-1:0] best;
      have  = 1'b0;
      best  = '0;
      grant = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (cand[i] && (!have || (key[i] < best))) begin
            have     = 1'b1;
            best     = key[i];
            grant    = '0;
            grant[i] = 1'b1;
         end
      end
   end

endmodule

// File: rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler: tick-driven RM / EDF task scheduler
// Each request transfer is one timer tick; each response transfer names the
// task that ran during that tick.
//
// req_tdata bit 0 is the restart flag: it clears all pending work and release
// countdowns before the tick is scheduled. rsp_tdata bits 3:0 carry the
// running task id, slot index plus one, or 0 when no task has work pending.
// The csr_ port writes the slot count, the policy, the packed execution
// times and the packed periods; write it only while no tick is in flight.
//
// From request transfer to response, the tick waits in the tick register,
// then the release, pick and charge logic settles in one pass into the
// response register, which drives rsp_tvalid. One tick is taken every
// cycle while the receiver keeps taking responses. The response register
// parts the two sides, so a tick is taken while the previous response waits;
// when the receiver stalls, the tick register holds one more tick and then
// req_tready drops until the response is taken. After reset all work and
// countdowns are zero, so every enabled task is released at the first tick;
// task_count resets to 1, the rest to 0.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
   parameter int TASK_SLOTS = 8,
   parameter int TICK_BITS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel: tdata = {7'b0, restart}
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ptts_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Response channel: tdata = {4'b0, running_task[3:0]}
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ptts_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Configuration write port
   input  logic                                 csr_wr_en,
   input  logic [ptts_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ptts_pkg::PACKED_BITS-1:0]     csr_wdata
);

   localparam int BB = ptts_pkg::SLOT_BYTE_BITS;
   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   ptts_pkg::cfg_type cfg;

   // Tick register and response register.
   logic                                 tick_valid_ff, tick_valid_in;
   logic                                 restart_ff, restart_in;
   logic                                 out_valid_ff, out_valid_in;
   logic [ptts_pkg::TASK_ID_BITS-1:0]    out_id_ff, out_id_in;
   logic                                 advance;

   // Per-slot scheduling state.
   logic [TASK_SLOTS-1:0][BB-1:0]        work_ff, work_in;
   logic [TASK_SLOTS-1:0][TICK_BITS-1:0] cnt_ff, cnt_in;

   // Release stage results feeding the pick.
   logic [TASK_SLOTS-1:0][BB-1:0]        work_rel;
   logic [TASK_SLOTS-1:0][TICK_BITS-1:0] cnt_rel;
   logic [TASK_SLOTS-1:0]                enabled;
   logic [TASK_SLOTS-1:0]                cand;
   logic [TASK_SLOTS-1:0][BB-1:0]        key;
   logic [TASK_SLOTS-1:0]                grant;

   ptts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The tick in the register is scheduled once the response register frees.
   assign advance    = tick_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !tick_valid_ff || advance;

   // Restart clearing, then release of every enabled slot whose countdown is zero.
   always_comb begin
      logic [BB-1:0]        period;
      logic [BB-1:0]        work0;
      logic [TICK_BITS-1:0] cnt0;
      logic [TICK_BITS-1:0] reload;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         period = cfg.periods[BB*i +: BB];
         work0  = restart_ff ? '0 : work_ff[i];
         cnt0   = restart_ff ? '0 : cnt_ff[i];
         reload = (period > BB'(TICK_MAX)) ? TICK_MAX : period[TICK_BITS-1:0];
         enabled[i] = (ptts_pkg::TASK_COUNT_BITS'(i) < cfg.task_count) && (period != '0);
         if (enabled[i] && (cnt0 == '0)) begin
            work_rel[i] = cfg.exec_times[BB*i +: BB];
            cnt_rel[i]  = reload;
         end else begin
            work_rel[i] = work0;
            cnt_rel[i]  = cnt0;
         end
         cand[i] = enabled[i] && (work_rel[i] != '0);
         key[i]  = (cfg.policy_mode == ptts_pkg::POLICY_EARLIEST_DL) ?
                   BB'(cnt_rel[i]) : period;
      end
   end

   ptts_select #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_select (
      .cand  (cand),
      .key   (key),
      .grant (grant)
   );

   // Charge the granted slot, step the countdowns and form the task id.
   always_comb begin
      out_id_in = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         work_in[i] = grant[i] ? (work_rel[i] - BB'(1)) : work_rel[i];
         cnt_in[i]  = (enabled[i] && (cnt_rel[i] != '0)) ?
                      (cnt_rel[i] - TICK_BITS'(1)) : cnt_rel[i];
         if (grant[i]) begin
            out_id_in = ptts_pkg::TASK_ID_BITS'(i + 1);
         end
      end
   end

   // Handshake bookkeeping for both registers.
   always_comb begin
      restart_in    = restart_ff;
      tick_valid_in = tick_valid_ff;
      if (req_tvalid && req_tready) begin
         tick_valid_in = 1'b1;
         restart_in    = req_tdata[0];
      end else if (advance) begin
         tick_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         work_ff       <= '0;
         cnt_ff        <= '0;
      end else begin
         tick_valid_ff <= tick_valid_in;
         out_valid_ff  <= out_valid_in;
         if (advance) begin
            work_ff <= work_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      restart_ff <= restart_in;
      if (advance) begin
         out_id_ff <= out_id_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(ptts_pkg::RSP_DATA_BITS - ptts_pkg::TASK_ID_BITS){1'b0}}, out_id_ff};

   // A reported task id never exceeds the slot range; 0 means no task ran.
   a_id_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(out_id_ff) <= TASK_SLOTS))
      else $error("running task id beyond slot range");

   // A stalled response must not be overwritten by a new tick.
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("tick scheduled over a stalled response");

   // Every scheduled tick produces a response in the next cycle.
   a_tick_to_rsp : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("scheduled tick produced no response");

   // At most one slot is charged per held tick, and only a pending one.
   a_one_grant : assert property (@(posedge clock) disable iff (reset)
      tick_valid_ff |-> ($onehot0(grant) && ((grant & ~cand) == '0)))
      else $error("grant not a single pending slot");

endmodule

// File: sim/ptts_schedule_checker.sv
// ----------------------------------------------------------------------------
// ptts_schedule_checker: running-task predictor and response checker
// Watches the tick, response and register-write ports of the scheduler,
// keeps its own copy of the task state and configuration, predicts the task
// run for every accepted tick and compares each response transfer with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module ptts_schedule_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [ptts_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [ptts_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ptts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ptts_pkg::PACKED_BITS-1:0]    csr_wdata,
   output int unsigned                         mismatch_count,
   output int unsigned                         pending_count
);

   localparam int SLOTS = 8;

   // Shadow configuration.
   logic [ptts_pkg::TASK_COUNT_BITS-1:0] task_count;
   logic                                 policy_mode;
   logic [ptts_pkg::PACKED_BITS-1:0]     exec_times;
   logic [ptts_pkg::PACKED_BITS-1:0]     periods;

   // Shadow task state.
   logic [ptts_pkg::SLOT_BYTE_BITS-1:0] work_left [SLOTS];
   logic [ptts_pkg::SLOT_BYTE_BITS-1:0] release_countdown [SLOTS];

   // Task ids still owed by the scheduler, oldest first.
   logic [ptts_pkg::TASK_ID_BITS-1:0] owed_task_q [$];

   // Advances the shadow state by one tick and returns the task id run in it.
   function automatic logic [ptts_pkg::TASK_ID_BITS-1:0] run_one_tick(input logic restart);
      int                                  active;
      int                                  pick;
      int                                  i;
      logic [ptts_pkg::SLOT_BYTE_BITS-1:0] period;
      logic [ptts_pkg::SLOT_BYTE_BITS-1:0] key;
      logic [ptts_pkg::SLOT_BYTE_BITS-1:0] best;
      active = (task_count > SLOTS) ? SLOTS : int'(task_count);
      pick   = -1;
      best   = '0;
      if (restart) begin
         for (i = 0; i < SLOTS; i++) begin
            work_left[i]         = '0;
            release_countdown[i] = '0;
         end
      end
      // Release every active slot whose countdown has expired. An 8-bit
      // period always fits the 8-bit countdown, so no clamp is needed.
      for (i = 0; i < active; i++) begin
         period = periods[8*i +: 8];
         if (period != 0 && release_countdown[i] == 0) begin
            work_left[i]         = exec_times[8*i +: 8];
            release_countdown[i] = period;
         end
      end
      // Pick the smallest key among slots with work; ties keep the lower slot.
      for (i = 0; i < active; i++) begin
         period = periods[8*i +: 8];
         if (period != 0 && work_left[i] != 0) begin
            key = (policy_mode == ptts_pkg::POLICY_EARLIEST_DL) ?
                  release_countdown[i] : period;
            if (pick < 0 || key < best) begin
               pick = i;
               best = key;
            end
         end
      end
      if (pick >= 0)
         work_left[pick] = work_left[pick] - 8'd1;
      // Every active slot with a nonzero period moves one tick closer to its next release.
      for (i = 0; i < active; i++) begin
         if (periods[8*i +: 8] != 0 && release_countdown[i] != 0)
            release_countdown[i] = release_countdown[i] - 8'd1;
      end
      return (pick < 0) ? '0 : ptts_pkg::TASK_ID_BITS'(pick + 1);
   endfunction

   // Track register writes, predict accepted ticks and check responses.
   always @(posedge clock) begin : monitor
      logic [ptts_pkg::TASK_ID_BITS-1:0] owed;
      if (reset) begin
         task_count  = ptts_pkg::TASK_COUNT_RESET;
         policy_mode = ptts_pkg::POLICY_RATE_MONOTONIC;
         exec_times  = '0;
         periods     = '0;
         for (int i = 0; i < SLOTS; i++) begin
            work_left[i]         = '0;
            release_countdown[i] = '0;
         end
         owed_task_q.delete();
         pending_count <= 0;
      end else begin
         if (csr_wr_en) begin
            case (ptts_pkg::csr_index_type'(csr_index))
               ptts_pkg::CSR_TASK_COUNT:
                  task_count  = csr_wdata[ptts_pkg::TASK_COUNT_BITS-1:0];
               ptts_pkg::CSR_POLICY_MODE: policy_mode = csr_wdata[0];
               ptts_pkg::CSR_EXEC_TIMES:  exec_times  = csr_wdata;
               ptts_pkg::CSR_PERIODS:     periods     = csr_wdata;
               default: ;
            endcase
         end

         // A response transfer is matched against the oldest owed task id.
         if (rsp_tvalid && rsp_tready) begin
            if (owed_task_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d",
                        $time, rsp_tdata[ptts_pkg::TASK_ID_BITS-1:0]);
               mismatch_count <= mismatch_count + 1;
            end else begin
               owed = owed_task_q.pop_front();
               if (rsp_tdata[ptts_pkg::TASK_ID_BITS-1:0] !== owed) begin
                  $display("%0t: running_task mismatch, expected %0d, actual %0d",
                           $time, owed, rsp_tdata[ptts_pkg::TASK_ID_BITS-1:0]);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end

         // Each tick transfer owes exactly one response.
         if (req_tvalid && req_tready)
            owed_task_q.push_back(run_one_tick(req_tdata[0]));

         pending_count <= owed_task_q.size();
      end
   end

endmodule

// File: sim/tb_periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_tick_scheduler: stimulus and verdict for the scheduler
// Drives timer ticks with occasional restarts under a series of task sets
// and policies: a short directed part on the corner cases, then random task
// sets under three idling patterns. The checker beside the block predicts
// and compares every response.
// ----------------------------------------------------------------------------
module tb_periodic_task_tick_scheduler;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [ptts_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [ptts_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               csr_wr_en  = 1'b0;
   ptts_pkg::csr_index_type            csr_index  = ptts_pkg::CSR_TASK_COUNT;
   logic [ptts_pkg::PACKED_BITS-1:0]   csr_wdata  = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned tick_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   always #5 clock = ~clock;

   // The receiver stalls at random at the current rate.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   periodic_task_tick_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ptts_schedule_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Watchdog for a hung handshake.
   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end

   // One tick transfer, preceded by a random idle gap.
   task automatic send_tick(input logic restart);
      while ($urandom_range(0, 99) < tick_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, restart};
      do @(posedge clock); while (!req_tready);
   endtask

   // Holds the ticks back until every owed response has been taken.
   task automatic drain_ticks();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Writes all four registers back to back once the block is idle.
   task automatic load_task_set(input logic [ptts_pkg::TASK_COUNT_BITS-1:0] count,
                                input logic                                 mode,
                                input logic [ptts_pkg::PACKED_BITS-1:0]     exec_bytes,
                                input logic [ptts_pkg::PACKED_BITS-1:0]     period_bytes);
      drain_ticks();
      csr_wr_en <= 1'b1;
      csr_index <= ptts_pkg::CSR_TASK_COUNT;
      csr_wdata <= ptts_pkg::PACKED_BITS'(count);
      @(posedge clock);
      csr_index <= ptts_pkg::CSR_POLICY_MODE;
      csr_wdata <= ptts_pkg::PACKED_BITS'(mode);
      @(posedge clock);
      csr_index <= ptts_pkg::CSR_EXEC_TIMES;
      csr_wdata <= exec_bytes;
      @(posedge clock);
      csr_index <= ptts_pkg::CSR_PERIODS;
      csr_wdata <= period_bytes;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly short periods so that releases and preemption happen often.
   function automatic logic [7:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'($urandom_range(17, 255));
         2:       return 8'hFF;
         default: return 8'($urandom_range(1, 16));
      endcase
   endfunction

   function automatic logic [7:0] pick_exec_time();
      case ($urandom_range(0, 9))
         0:       return 8'd0;
         1:       return 8'($urandom_range(0, 255));
         2:       return 8'hFF;
         default: return 8'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin : stimulus
      logic [ptts_pkg::PACKED_BITS-1:0]     exec_bytes;
      logic [ptts_pkg::PACKED_BITS-1:0]     period_bytes;
      logic [ptts_pkg::TASK_COUNT_BITS-1:0] count;
      int                                   ticks;
      int                                   mode_sel;
      int                                   set_sel;
      int                                   n;
      int                                   s;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tick_idle_pct = 25;
      rsp_stall_pct = 68;

      // Reset configuration: one slot with period zero, so the block idles.
      send_tick(1'b0);
      send_tick(1'b1);

      // Rate monotonic over all slots: a tie on period 2, a disabled slot,
      // a zero execution time, the largest period and execution time.
      load_task_set(4'd8, ptts_pkg::POLICY_RATE_MONOTONIC,
                    64'h01_02_03_01_00_01_FF_02, 64'hFF_06_00_02_01_02_FF_04);
      for (n = 0; n < 8; n++)
         send_tick(n == 5);

      // Earliest deadline first with a slot count above the slot range.
      load_task_set(4'd15, ptts_pkg::POLICY_EARLIEST_DL,
                    64'h01_02_03_01_00_01_FF_02, 64'hFF_06_00_02_01_02_FF_04);
      for (n = 0; n < 7; n++)
         send_tick(n == 3);

      // No active slot at all, then a few slots released every tick.
      load_task_set(4'd0, ptts_pkg::POLICY_EARLIEST_DL, '1,
                    64'h01_01_01_01_01_01_01_01);
      for (n = 0; n < 3; n++)
         send_tick(1'b0);
      load_task_set(4'd3, ptts_pkg::POLICY_RATE_MONOTONIC, '1,
                    64'h01_01_01_01_01_01_01_01);
      for (n = 0; n < 3; n++)
         send_tick(1'b0);

      // Random task sets under each idling pattern.
      for (mode_sel = 0; mode_sel < 3; mode_sel++) begin
         case (mode_sel)
            0: begin
               tick_idle_pct = 25;
               rsp_stall_pct = 68;
            end
            1: begin
               tick_idle_pct = 68;
               rsp_stall_pct = 25;
            end
            default: begin
               tick_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         for (set_sel = 0; set_sel < 7; set_sel++) begin
            for (s = 0; s < 8; s++) begin
               exec_bytes[8*s +: 8]   = pick_exec_time();
               period_bytes[8*s +: 8] = pick_period();
            end
            if ($urandom_range(0, 9) == 0)
               count = 4'($urandom_range(0, 15));
            else
               count = 4'($urandom_range(1, 8));
            load_task_set(count, 1'($urandom_range(0, 1)), exec_bytes, period_bytes);
            ticks = $urandom_range(40, 80);
            for (n = 0; n < ticks; n++) begin
               // Midway through each set, let the block drain completely.
               if (n == ticks / 2)
                  drain_ticks();
               send_tick($urandom_range(0, 99) < 3);
            end
         end
      end

      drain_ticks();
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
